// ----- src/teq_pkg.sv -----
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types and codes for the timed event queue: word formats, action and
// status codes, and the command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package teq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;
	localparam logic [1:0] ACT_GET    = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  event_id;
		logic [15:0] delay_ticks;
		logic        tick;
	} teq_in_t;

	typedef struct packed {
		logic [7:0] event_out;
		logic [1:0] status;
	} teq_out_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;   // input word taken this edge
		logic scan;     // register the match vector
		logic commit;   // apply the update and load the result
	} teq_cmd_t;

	// datapath -> checks
	typedef struct packed {
		logic full;
	} teq_stat_t;

endpackage

// ----- src/teq_ctrl.sv -----
// ----------------------------------------------------------------------------
// teq_ctrl
// Sequencer for the timed event queue: accept, scan, commit, and the valid
// flag of the output register.
// ----------------------------------------------------------------------------
module teq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output teq_pkg::teq_cmd_t cmd
);
	import teq_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic       out_valid_q;
	logic       commit_ok;

	// commit only when the output register is free or being emptied
	assign commit_ok = (state_q == S_COMMIT) && (!out_valid_q || out_ready);

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign cmd.accept = in_valid && in_ready;
	assign cmd.scan   = (state_q == S_SCAN);
	assign cmd.commit = commit_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_SCAN;
				end
				S_SCAN: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (commit_ok) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit_ok) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- src/teq_dpath.sv -----
// ----------------------------------------------------------------------------
// teq_dpath
// Slot cells of the timed event queue with per-slot compare, shift-down on
// removal, tick counters, and the output word register.
// ----------------------------------------------------------------------------
module teq_dpath #(
	parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  teq_pkg::teq_cmd_t  cmd,
	input  teq_pkg::teq_in_t   in_data,
	output teq_pkg::teq_out_t  out_data,
	output teq_pkg::teq_stat_t stat
);
	import teq_pkg::*;

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	teq_in_t     cmd_q;
	teq_out_t    out_q;
	logic [7:0]  ev_q  [QUEUE_DEPTH];
	logic [15:0] dly_q [QUEUE_DEPTH];
	logic [15:0] ela_q [QUEUE_DEPTH];
	logic [CW-1:0] fill_q;

	logic [QUEUE_DEPTH-1:0] valid, match, first, shift;
	logic [QUEUE_DEPTH-1:0] shift_q;
	logic                   found_q;
	logic [7:0]             pop_q;
	logic [7:0]             pop_ev;

	logic [7:0]  ev_up  [QUEUE_DEPTH];
	logic [15:0] dly_up [QUEUE_DEPTH];
	logic [15:0] ela_up [QUEUE_DEPTH];

	// per-slot compare; shift marks the first hit and every slot above it
	always_comb begin
		pop_ev = '0;
		for (int k = 0; k < QUEUE_DEPTH; k++) begin
			valid[k] = CW'(k) < fill_q;
			case (cmd_q.action)
				ACT_REMOVE: match[k] = valid[k] && (cmd_q.event_id != 8'd0) &&
					(ev_q[k] == cmd_q.event_id);
				ACT_GET:    match[k] = valid[k] &&
					((dly_q[k] == 16'd0) || (ela_q[k] >= dly_q[k]));
				default:    match[k] = 1'b0;
			endcase
		end
		for (int k = 0; k < QUEUE_DEPTH; k++) begin
			shift[k] = |(match & QUEUE_DEPTH'((2 * (64'd1 << k)) - 64'd1));
			first[k] = match[k] && !(|(match & QUEUE_DEPTH'((64'd1 << k) - 64'd1)));
			pop_ev   = pop_ev | (first[k] ? ev_q[k] : 8'd0);
		end
	end

	// neighbor above each slot; the top slot takes zeros
	always_comb begin
		for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
			ev_up[k]  = ev_q[k+1];
			dly_up[k] = dly_q[k+1];
			ela_up[k] = ela_q[k+1];
		end
		ev_up[QUEUE_DEPTH-1]  = '0;
		dly_up[QUEUE_DEPTH-1] = '0;
		ela_up[QUEUE_DEPTH-1] = '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) cmd_q <= in_data;
		if (cmd.scan) begin
			shift_q <= shift;
			found_q <= |match;
			pop_q   <= pop_ev;
		end
		if (cmd.commit) begin
			out_q.event_out <= (cmd_q.action == ACT_GET && found_q) ? pop_q : 8'd0;
			if (cmd_q.action == ACT_INSERT && cmd_q.event_id != 8'd0 && fill_q == DEPTH_C)
				out_q.status <= ST_FULL;
			else if (cmd_q.action == ACT_REMOVE && !found_q)
				out_q.status <= ST_NOTFOUND;
			else
				out_q.status <= ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			for (int k = 0; k < QUEUE_DEPTH; k++) begin
				ev_q[k]  <= '0;
				dly_q[k] <= '0;
				ela_q[k] <= '0;
			end
		end else if (cmd.accept) begin
			// tick advances delayed entries before the ready scan
			if (in_data.action == ACT_GET && in_data.tick) begin
				for (int k = 0; k < QUEUE_DEPTH; k++) begin
					if (valid[k] && dly_q[k] != 16'd0 && ela_q[k] != 16'hFFFF)
						ela_q[k] <= ela_q[k] + 16'd1;
				end
			end
		end else if (cmd.commit) begin
			case (cmd_q.action)
				ACT_CLEAR: begin
					fill_q <= '0;
					for (int k = 0; k < QUEUE_DEPTH; k++) begin
						ev_q[k]  <= '0;
						dly_q[k] <= '0;
						ela_q[k] <= '0;
					end
				end
				ACT_INSERT: begin
					if (cmd_q.event_id != 8'd0 && fill_q < DEPTH_C) begin
						ev_q[fill_q[IW-1:0]]  <= cmd_q.event_id;
						dly_q[fill_q[IW-1:0]] <= cmd_q.delay_ticks;
						ela_q[fill_q[IW-1:0]] <= '0;
						fill_q <= fill_q + CW'(1);
					end
				end
				default: begin
					// remove or get: close the gap above the hit
					if (found_q) begin
						fill_q <= fill_q - CW'(1);
						for (int k = 0; k < QUEUE_DEPTH; k++) begin
							if (shift_q[k]) begin
								ev_q[k]  <= ev_up[k];
								dly_q[k] <= dly_up[k];
								ela_q[k] <= ela_up[k];
							end
						end
					end
				end
			endcase
		end
	end

	assign out_data   = out_q;
	assign stat.full  = (fill_q == DEPTH_C);

endmodule

// ----- src/timed_event_queue.sv -----
// ----------------------------------------------------------------------------
// timed_event_queue
// Compacted queue of pending events with delays; clear, insert, remove by id
// and get-ready commands, one result word per command word.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data): one command word carrying
//   action, event_id, delay_ticks and tick. in_ready is high only when the
//   sequencer is idle.
//   out channel (out_valid/out_ready/out_data): exactly one result word per
//   command, event_out and status, held in an output register.
//   Timing: a word is taken in the accept step (a get with tick advances the
//   elapsed counts there), the slot compare is registered in the scan step,
//   and the update plus result load happen in the commit step. The result is
//   visible after the commit, and in_ready returns then; the sequencer steps
//   through accept, scan and commit in that order for every command.
//   The next word may be accepted while the previous result still waits.
//   Receiver stall: if the output register is still full at commit time,
//   the commit step holds (queue untouched) until out_ready frees it.
//   Reset: all slots zero, queue empty, no result pending, ready to accept.
// ----------------------------------------------------------------------------
module timed_event_queue #(
	parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  teq_pkg::teq_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output teq_pkg::teq_out_t out_data
);
	import teq_pkg::*;

	teq_cmd_t  cmd;   // sequencer commands
	teq_stat_t stat;  // queue full flag

	teq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	teq_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.out_data (out_data),
		.stat     (stat)
	);

	// After taking a word the block is busy until the commit.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("accepted a word while a command was in flight");

	// A fresh result coincides with the sequencer going idle.
	a_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result loaded outside the commit step");

	// A dropped insert is reported only while the queue is full.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == ST_FULL) |-> stat.full)
		else $error("full status with room in the queue");

	// A popped event never comes with an error status.
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.event_out != 8'd0) |-> (out_data.status == ST_OK))
		else $error("event returned with error status");

endmodule
